### hdl/yaz0_pkg.sv
// ============================================================================
// yaz0_pkg
// Shared types and constants for the streaming Yaz0 decompressor.
// ============================================================================
`default_nettype none

package yaz0_pkg;

    // header layout
    localparam logic [4:0] HEADER_LEN = 5'h10;
    localparam logic [4:0] MAGIC_LEN  = 5'd4;
    localparam logic [4:0] SIZE_END   = 5'd8;

    // token decoding
    localparam logic [7:0] LIT_FLAG       = 8'h80;
    localparam logic [7:0] DIST_HI_MASK   = 8'h0F;
    localparam logic [8:0] LONG_LEN_BIAS  = 9'h012;
    localparam logic [8:0] SHORT_LEN_BIAS = 9'd2;

    // size limit after reset and counter widths
    localparam logic [28:0] SIZE_LIMIT_RESET = 29'(256 * 1024 * 1024);
    localparam int          SIZE_W           = 32;
    localparam int          PROD_W           = 30;
    localparam int          COPY_W           = 9;
    localparam int          DIST_W           = 12;

    // final status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_MAGIC = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_TRUNCATED = 3'd3,
        ST_BAD_DIST  = 3'd4,
        ST_OVERRUN   = 3'd5
    } status_t;

    // sequencer to lane packer
    typedef struct packed {
        logic    push;
        logic    flush;
        logic    done;
        status_t status;
    } pack_ctrl_t;

    // lane packer to sequencer
    typedef struct packed {
        logic lane_full;
        logic lane_empty;
        logic slot_free;
    } pack_stat_t;

    // expected magic "Yaz0"
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] val;
        unique case (idx)
            2'd0:    val = 8'h59;
            2'd1:    val = 8'h61;
            2'd2:    val = 8'h7A;
            default: val = 8'h30;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

### hdl/yaz0_if.sv
// ============================================================================
// yaz0 stream interfaces
// Valid/ready channels for compressed input bytes and packed output results.
// ============================================================================
`default_nettype none

interface yaz0_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] compressed_byte;
    logic       end_of_input;

    modport source (output valid, output compressed_byte, output end_of_input,
                    input ready);
    modport sink   (input valid, input compressed_byte, input end_of_input,
                    output ready);
endinterface

interface yaz0_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] output_bytes;
    logic [3:0]  byte_count;
    logic        run_last;
    logic        stream_done;
    logic [2:0]  status;

    modport source (output valid, output output_bytes, output byte_count,
                    output run_last, output stream_done, output status,
                    input ready);
    modport sink   (input valid, input output_bytes, input byte_count,
                    input run_last, input stream_done, input status,
                    output ready);
endinterface

`default_nettype wire

### hdl/yaz0_lz_decompressor.sv
// ============================================================================
// yaz0_lz_decompressor
// Streaming Yaz0 decompressor: header check, token decode, history copy.
// ============================================================================
// Takes one compressed byte per input transaction, whole stream including the
// 16-byte header, and returns packed output bytes (up to OUT_LANES per result,
// first byte in the lowest lane) plus one final status per stream. The input
// is not ready while a byte is being worked on. A header, group or reference
// control byte passes decode and final, a literal also literal and token end,
// a copy a read and a write per byte then token end: each copied byte is a
// read then a write of the single history RAM, so overlapping copies repeat;
// a stalled result port holds the flow. History needs no clearing after reset;
// copies only read bytes written earlier in the same stream. The user writes
// max_output_size via cfg_wr_en/cfg_wr_data only while idle; not enforced.
`default_nettype none

module yaz0_lz_decompressor #(
    parameter int WINDOW_DEPTH = 4096,
    parameter int OUT_LANES    = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [28:0] cfg_wr_data,
    yaz0_in_if.sink          stream,
    yaz0_out_if.source       result
);

    localparam int ADDR_W = $clog2(WINDOW_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_LIT,
        S_COPY_RD,
        S_COPY_WR,
        S_TOKEN_END,
        S_FINAL
    } state_t;

    typedef enum logic [1:0] {
        PH_TOKEN,
        PH_SECOND,
        PH_EXTRA
    } phase_t;

    state_t                            state_reg, state_next;
    logic [7:0]                        byte_reg, byte_next;
    logic                              last_reg, last_next;
    logic                              active_reg, active_next;
    logic                              done_reg, done_next;
    yaz0_pkg::status_t                 st_reg, st_next;
    logic [28:0]                       max_reg, max_next;
    logic [4:0]                        header_idx_reg, header_idx_next;
    logic [yaz0_pkg::SIZE_W-1:0]       declared_reg, declared_next;
    logic [yaz0_pkg::PROD_W-1:0]       produced_reg, produced_next;
    logic [7:0]                        group_reg, group_next;
    logic [3:0]                        bits_left_reg, bits_left_next;
    phase_t                            phase_reg, phase_next;
    logic [7:0]                        ref1_reg, ref1_next;
    logic [7:0]                        ref2_reg, ref2_next;
    logic                              finished_reg, finished_next;
    logic [yaz0_pkg::DIST_W-1:0]       dist_reg, dist_next;
    logic [yaz0_pkg::COPY_W-1:0]       copy_left_reg, copy_left_next;

    yaz0_pkg::pack_ctrl_t              pctrl;
    yaz0_pkg::pack_stat_t              pstat;
    logic [7:0]                        push_data;
    logic [7:0]                        hist_rdata;
    logic [ADDR_W-1:0]                 hist_raddr;

    // history read address trails the write pointer by distance + 1
    assign hist_raddr = produced_reg[ADDR_W-1:0] - ADDR_W'(dist_reg) - ADDR_W'(1);
    assign push_data  = (state_reg == S_LIT) ? byte_reg : hist_rdata;

    assign stream.ready = (state_reg == S_IDLE);

    // sequencer
    always_comb
    begin
        logic                         end_stream;
        yaz0_pkg::status_t            end_status;
        logic                         start_copy;
        logic [yaz0_pkg::COPY_W-1:0]  copy_len;
        logic [yaz0_pkg::DIST_W-1:0]  copy_dist;
        logic                         push_ok;
        logic                         fin_done;
        logic                         fin_need;

        end_stream = 1'b0;
        end_status = yaz0_pkg::ST_OK;
        start_copy = 1'b0;
        copy_len   = '0;
        copy_dist  = '0;
        push_ok    = !pstat.lane_full || pstat.slot_free;
        fin_done   = done_reg || (last_reg && active_reg);
        fin_need   = fin_done || !pstat.lane_empty;

        state_next      = state_reg;
        byte_next       = byte_reg;
        last_next       = last_reg;
        active_next     = active_reg;
        done_next       = done_reg;
        st_next         = st_reg;
        max_next        = cfg_wr_en ? cfg_wr_data : max_reg;
        header_idx_next = header_idx_reg;
        declared_next   = declared_reg;
        produced_next   = produced_reg;
        group_next      = group_reg;
        bits_left_next  = bits_left_reg;
        phase_next      = phase_reg;
        ref1_next       = ref1_reg;
        ref2_next       = ref2_reg;
        finished_next   = finished_reg;
        dist_next       = dist_reg;
        copy_left_next  = copy_left_reg;

        pctrl.push   = 1'b0;
        pctrl.flush  = 1'b0;
        pctrl.done   = fin_done;
        pctrl.status = done_reg ? st_reg : yaz0_pkg::ST_TRUNCATED;

        unique case (state_reg)
            S_IDLE:
            begin
                if (stream.valid)
                begin
                    byte_next  = stream.compressed_byte;
                    last_next  = stream.end_of_input;
                    done_next  = 1'b0;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                active_next = !finished_reg;
                state_next  = S_FINAL;
                if (finished_reg)
                begin
                    // stream already ended: byte is dropped
                end
                else if (header_idx_reg < yaz0_pkg::HEADER_LEN)
                begin
                    header_idx_next = header_idx_reg + 5'd1;
                    if (header_idx_reg < yaz0_pkg::MAGIC_LEN)
                    begin
                        if (byte_reg != yaz0_pkg::magic_byte(header_idx_reg[1:0]))
                        begin
                            end_stream = 1'b1;
                            end_status = yaz0_pkg::ST_BAD_MAGIC;
                        end
                    end
                    else if (header_idx_reg < yaz0_pkg::SIZE_END)
                    begin
                        declared_next = {declared_reg[yaz0_pkg::SIZE_W-9:0], byte_reg};
                        if (header_idx_reg == yaz0_pkg::SIZE_END - 5'd1 &&
                            declared_next > yaz0_pkg::SIZE_W'(max_reg))
                        begin
                            end_stream = 1'b1;
                            end_status = yaz0_pkg::ST_TOO_LARGE;
                        end
                    end
                    // empty output ends right after the header
                    if (header_idx_next == yaz0_pkg::HEADER_LEN && declared_next == '0)
                    begin
                        end_stream = 1'b1;
                        end_status = yaz0_pkg::ST_OK;
                    end
                end
                else if (bits_left_reg == '0)
                begin
                    group_next     = byte_reg;
                    bits_left_next = 4'd8;
                    phase_next     = PH_TOKEN;
                end
                else
                begin
                    case (phase_reg)
                        PH_TOKEN:
                        begin
                            if ((group_reg & yaz0_pkg::LIT_FLAG) != '0)
                            begin
                                state_next = S_LIT;
                            end
                            else
                            begin
                                ref1_next  = byte_reg;
                                phase_next = PH_SECOND;
                            end
                        end
                        PH_SECOND:
                        begin
                            ref2_next = byte_reg;
                            if (ref1_reg[7:4] == 4'd0)
                            begin
                                phase_next = PH_EXTRA;
                            end
                            else
                            begin
                                start_copy = 1'b1;
                                copy_len   = yaz0_pkg::COPY_W'(ref1_reg[7:4]) +
                                             yaz0_pkg::SHORT_LEN_BIAS;
                                copy_dist  = {4'(ref1_reg & yaz0_pkg::DIST_HI_MASK),
                                              byte_reg};
                            end
                        end
                        PH_EXTRA:
                        begin
                            start_copy = 1'b1;
                            copy_len   = yaz0_pkg::COPY_W'(byte_reg) +
                                         yaz0_pkg::LONG_LEN_BIAS;
                            copy_dist  = {4'(ref1_reg & yaz0_pkg::DIST_HI_MASK), ref2_reg};
                        end
                        default:
                        begin
                            phase_next = PH_TOKEN;
                        end
                    endcase
                end

                // back-reference must stay inside what was produced
                if (start_copy)
                begin
                    if (produced_reg <= yaz0_pkg::PROD_W'(copy_dist))
                    begin
                        end_stream = 1'b1;
                        end_status = yaz0_pkg::ST_BAD_DIST;
                    end
                    else
                    begin
                        dist_next      = copy_dist;
                        copy_left_next = copy_len;
                        state_next     = S_COPY_RD;
                    end
                end
            end

            S_LIT:
            begin
                if (push_ok)
                begin
                    pctrl.push    = 1'b1;
                    produced_next = produced_reg + yaz0_pkg::PROD_W'(1);
                    state_next    = S_TOKEN_END;
                end
            end

            S_COPY_RD:
            begin
                state_next = S_COPY_WR;
            end

            S_COPY_WR:
            begin
                if (push_ok)
                begin
                    pctrl.push     = 1'b1;
                    produced_next  = produced_reg + yaz0_pkg::PROD_W'(1);
                    copy_left_next = copy_left_reg - yaz0_pkg::COPY_W'(1);
                    state_next     = (copy_left_reg == yaz0_pkg::COPY_W'(1)) ?
                                     S_TOKEN_END : S_COPY_RD;
                end
            end

            S_TOKEN_END:
            begin
                phase_next     = PH_TOKEN;
                group_next     = {group_reg[6:0], 1'b0};
                bits_left_next = bits_left_reg - 4'd1;
                state_next     = S_FINAL;
                if (yaz0_pkg::SIZE_W'(produced_reg) >= declared_reg)
                begin
                    end_stream = 1'b1;
                    end_status = (yaz0_pkg::SIZE_W'(produced_reg) == declared_reg) ?
                                 yaz0_pkg::ST_OK : yaz0_pkg::ST_OVERRUN;
                end
            end

            S_FINAL:
            begin
                if (!fin_need || pstat.slot_free)
                begin
                    pctrl.flush = fin_need;
                    state_next  = S_IDLE;
                    // end of input clears the stream for the next one
                    if (last_reg)
                    begin
                        header_idx_next = '0;
                        declared_next   = '0;
                        produced_next   = '0;
                        group_next      = '0;
                        bits_left_next  = '0;
                        phase_next      = PH_TOKEN;
                        ref1_next       = '0;
                        ref2_next       = '0;
                        finished_next   = 1'b0;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (end_stream)
        begin
            done_next     = 1'b1;
            st_next       = end_status;
            finished_next = 1'b1;
        end
    end

    // state and registered control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            last_reg       <= 1'b0;
            active_reg     <= 1'b0;
            done_reg       <= 1'b0;
            st_reg         <= yaz0_pkg::ST_OK;
            max_reg        <= yaz0_pkg::SIZE_LIMIT_RESET;
            header_idx_reg <= '0;
            declared_reg   <= '0;
            produced_reg   <= '0;
            group_reg      <= '0;
            bits_left_reg  <= '0;
            phase_reg      <= PH_TOKEN;
            ref1_reg       <= '0;
            ref2_reg       <= '0;
            finished_reg   <= 1'b0;
            copy_left_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            last_reg       <= last_next;
            active_reg     <= active_next;
            done_reg       <= done_next;
            st_reg         <= st_next;
            max_reg        <= max_next;
            header_idx_reg <= header_idx_next;
            declared_reg   <= declared_next;
            produced_reg   <= produced_next;
            group_reg      <= group_next;
            bits_left_reg  <= bits_left_next;
            phase_reg      <= phase_next;
            ref1_reg       <= ref1_next;
            ref2_reg       <= ref2_next;
            finished_reg   <= finished_next;
            copy_left_reg  <= copy_left_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        dist_reg <= dist_next;
    end

    // history window
    yaz0_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_DEPTH)
    ) u_history (
        .clk     (clk),
        .wr_en   (pctrl.push),
        .wr_addr (produced_reg[ADDR_W-1:0]),
        .wr_data (push_data),
        .rd_addr (hist_raddr),
        .rd_data (hist_rdata)
    );

    // output lane packing and result register
    yaz0_lane_pack #(
        .OUT_LANES (OUT_LANES)
    ) u_lane_pack (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (pctrl),
        .data   (push_data),
        .stat   (pstat),
        .result (result)
    );

    // copy never runs with nothing left to copy
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_COPY_WR |-> copy_left_reg != '0)
        else $error("copy step with zero bytes left");

    // copy source always lies in bytes already produced
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_COPY_WR |-> produced_reg > yaz0_pkg::PROD_W'(dist_reg))
        else $error("copy source outside produced output");

    // a final status without end of input leaves the stream finished
    assert property (@(posedge clk) disable iff (!rst_n)
        pctrl.flush && pctrl.done && !last_reg |=> finished_reg)
        else $error("stream ended but not marked finished");

    // no group bits are pending while the header is parsed
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DECODE && header_idx_reg < yaz0_pkg::HEADER_LEN
        |-> bits_left_reg == '0)
        else $error("group bits pending during header");

endmodule

`default_nettype wire

### hdl/yaz0_ram.sv
// ============================================================================
// yaz0_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module yaz0_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### hdl/yaz0_lane_pack.sv
// ============================================================================
// yaz0_lane_pack
// Packs output bytes into lanes and holds the outgoing result transaction.
// ============================================================================
`default_nettype none

module yaz0_lane_pack #(
    parameter int OUT_LANES = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire yaz0_pkg::pack_ctrl_t  ctrl,
    input  wire logic [7:0]            data,
    output yaz0_pkg::pack_stat_t       stat,
    yaz0_out_if.source                 result
);

    localparam int CNT_W = $clog2(OUT_LANES + 1);

    logic [OUT_LANES-1:0][7:0] lane_reg, lane_next;
    logic [CNT_W-1:0]          lane_n_reg, lane_n_next;

    logic                      out_valid_reg;
    logic [63:0]               out_bytes_reg;
    logic [3:0]                out_count_reg;
    logic                      out_last_reg;
    logic                      out_done_reg;
    yaz0_pkg::status_t         out_status_reg;

    logic                      emit_full;
    logic                      emit;

    // status toward the sequencer
    assign stat.lane_full  = (lane_n_reg == CNT_W'(OUT_LANES));
    assign stat.lane_empty = (lane_n_reg == '0);
    assign stat.slot_free  = !out_valid_reg || result.ready;

    // a push into a full lane sends the lane out first
    assign emit_full = ctrl.push && stat.lane_full;
    assign emit      = emit_full || ctrl.flush;

    // lane accumulator next state
    always_comb
    begin
        lane_next   = lane_reg;
        lane_n_next = lane_n_reg;
        if (emit_full)
        begin
            lane_next    = '0;
            lane_next[0] = data;
            lane_n_next  = CNT_W'(1);
        end
        else if (ctrl.flush)
        begin
            lane_next   = '0;
            lane_n_next = '0;
        end
        else if (ctrl.push)
        begin
            for (int i = 0; i < OUT_LANES; i++)
            begin
                if (lane_n_reg == CNT_W'(i))
                begin
                    lane_next[i] = data;
                end
            end
            lane_n_next = lane_n_reg + CNT_W'(1);
        end
    end

    // lane and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_reg      <= '0;
            lane_n_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lane_reg   <= lane_next;
            lane_n_reg <= lane_n_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_bytes_reg  <= 64'(lane_reg);
            out_count_reg  <= 4'(lane_n_reg);
            out_last_reg   <= ctrl.flush;
            out_done_reg   <= ctrl.flush && ctrl.done;
            out_status_reg <= (ctrl.flush && ctrl.done) ? ctrl.status : yaz0_pkg::ST_OK;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.output_bytes = out_bytes_reg;
    assign result.byte_count   = out_count_reg;
    assign result.run_last     = out_last_reg;
    assign result.stream_done  = out_done_reg;
    assign result.status       = out_status_reg;

endmodule

`default_nettype wire
